[design/mpm2d_pkg.sv]
// ----------------------------------------------------------------------------
// mpm2d_pkg
// Shared constants, register codes and helpers for the 2-D prefix maximum.
// ----------------------------------------------------------------------------
package mpm2d_pkg;

  // Default sizing of the block.
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_DATA_WIDTH = 32;

  // Width of the size registers and of the result port.
  localparam int SIZE_W = 11;
  localparam int OUT_W  = 32;

  // Configuration port: two 32-bit registers at byte addresses 0 and 4.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Size registers come out of reset holding 1024.
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef enum logic [0:0] {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } cfg_reg_t;

  // A size of zero acts as one, and a size above the limit acts as the limit.
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int hi);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > hi) begin
      res = SIZE_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[design/mpm2d_ram.sv]
// ----------------------------------------------------------------------------
// mpm2d_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpm2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/matrix_prefix_max_2d.sv]
// ----------------------------------------------------------------------------
// matrix_prefix_max_2d
// Streaming two-dimensional prefix maximum over a raster-ordered matrix.
// ----------------------------------------------------------------------------
// The block takes one signed matrix element per transfer, row by row and left
// to right, and returns one result per element: the maximum of every element
// of the current frame at or above its row and at or left of its column, with
// frame_end set on the last element of the frame. It sustains one transfer
// per clock cycle while the output side is not stalled. Each result comes
// from a single read-modify-write pass through the line buffer memory: the
// entry above is read in the cycle of the input transfer, and the result is
// written back when the item leaves stage 1. The line buffer needs no
// clearing after reset, because first-row results ignore what it returns.
// The frame size is set through the configuration port (num_cols at byte
// address 0, num_rows at byte address 4) and should only be changed while
// the block is idle.
// ----------------------------------------------------------------------------
module matrix_prefix_max_2d #(
  parameter int MAX_COLS   = mpm2d_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = mpm2d_pkg::DEF_MAX_ROWS,
  parameter int DATA_WIDTH = mpm2d_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpm2d_pkg::PADDR_W-1:0]       paddr,
  input  logic [mpm2d_pkg::PDATA_W-1:0]       pwdata,
  output logic [mpm2d_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        value,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mpm2d_pkg::OUT_W-1:0]  max_value,
  output logic                                frame_end
);

  import mpm2d_pkg::*;

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMPW = ((CW > SIZE_W) ? CW : SIZE_W) + ((RW > SIZE_W) ? 1 : 0)
                        + ((RW > CW) ? RW : 0);

  // --------------------------------------------------------------------------
  // Configuration registers. They hold the size after clamping, so a read
  // returns the size that is in force.
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] num_cols;
  logic [SIZE_W-1:0] num_rows;
  logic              cfg_we;
  cfg_reg_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[PADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= clamp_size(SIZE_RESET, MAX_COLS);
      num_rows <= clamp_size(SIZE_RESET, MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NUM_COLS: num_cols <= clamp_size(pwdata[SIZE_W-1:0], MAX_COLS);
        REG_NUM_ROWS: num_rows <= clamp_size(pwdata[SIZE_W-1:0], MAX_ROWS);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_COLS: prdata = PDATA_W'(num_cols);
      REG_NUM_ROWS: prdata = PDATA_W'(num_rows);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 0: input transfer. The running row maximum and the raster position
  // advance here, and the line buffer entry of the current column is read.
  // --------------------------------------------------------------------------
  logic                         in_fire;
  logic [CW-1:0]                col_index;
  logic [RW-1:0]                row_index;
  logic signed [DATA_WIDTH-1:0] row_max;
  logic signed [DATA_WIDTH-1:0] row_max_next;
  logic                         row_end;
  logic                         frame_last;

  assign in_fire = in_valid & in_ready;

  // The first column restarts the running maximum at the incoming element.
  assign row_max_next = (col_index == '0) ? value :
                        ((value > row_max) ? value : row_max);

  // A row ends once the column reaches the last one of the current size; the
  // compare is made at a common width so that any parameter values work.
  assign row_end    = CMPW'(col_index) >= (CMPW'(num_cols) - CMPW'(1));
  assign frame_last = row_end && (CMPW'(row_index) >= (CMPW'(num_rows) - CMPW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
      row_max   <= '0;
    end else if (in_fire) begin
      row_max <= row_max_next;
      if (row_end) begin
        col_index <= '0;
        row_index <= frame_last ? '0 : row_index + RW'(1);
      end else begin
        col_index <= col_index + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the read data of the entry above arrives, the result is formed
  // and written back into the line buffer as the item moves to the output.
  // --------------------------------------------------------------------------
  logic                         s1_valid;
  logic [CW-1:0]                s1_col;
  logic signed [DATA_WIDTH-1:0] s1_row_max;
  logic                         s1_first_row;
  logic                         s1_last;
  logic                         s1_adv;
  logic signed [DATA_WIDTH-1:0] s1_above;
  logic signed [DATA_WIDTH-1:0] s1_res;
  logic [CW-1:0]                rd_addr;
  logic [DATA_WIDTH-1:0]        rd_data;
  logic                         fwd;
  logic signed [DATA_WIDTH-1:0] fwd_data;

  logic signed [DATA_WIDTH-1:0] out_res;

  assign s1_adv   = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | s1_adv;

  // While stage 1 is stalled the RAM keeps reading its column, so the read
  // data stays current for as long as the item waits.
  assign rd_addr = in_fire ? col_index : s1_col;

  // When one-column rows make an item read the entry that its predecessor is
  // writing in the same cycle, the RAM returns the old contents; the written
  // value is forwarded in its place.
  assign s1_above = fwd ? fwd_data : $signed(rd_data);
  assign s1_res   = (s1_first_row || (s1_row_max > s1_above)) ? s1_row_max : s1_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      fwd <= in_fire & s1_adv & (col_index == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= s1_res;
    if (in_fire) begin
      s1_col       <= col_index;
      s1_row_max   <= row_max_next;
      s1_first_row <= (row_index == '0);
      s1_last      <= frame_last;
    end
  end

  mpm2d_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line_buffer (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_res),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // Output register. It parts the two sides, so a waiting result does not
  // hold up the next input transfer until stage 1 is also full.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res   <= s1_res;
      frame_end <= s1_last;
    end
  end

  // The result port carries the low 32 bits; narrower data is zero-extended.
  generate
    if (DATA_WIDTH >= OUT_W) begin : g_out_trunc
      assign max_value = out_res[OUT_W-1:0];
    end else begin : g_out_ext
      assign max_value = {{(OUT_W-DATA_WIDTH){1'b0}}, out_res};
    end
  endgenerate

`ifndef SYNTHESIS
  // An accepted input always occupies stage 1 in the following cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item did not reach stage 1");

  // A stalled stage 1 keeps its item and its column.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_col)))
    else $error("stalled stage 1 lost its item");

  // Forwarding only ever serves an item that sits in stage 1.
  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_valid)
    else $error("forwarding without an item in stage 1");

  // A result moves out only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !s1_adv)
    else $error("stage 1 overwrote a waiting result");
`endif

endmodule
